// ----- rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// ----- rtl/bsws_pkg.sv -----
// types and constants of the bounded stack with search
`timescale 1ns / 1ps

package bsws_pkg;

    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;
    localparam int CAP_W    = 5;
    localparam int WALK_MAX = 16;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_SEARCH = 3'd3,
        OP_DUMP   = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_DONE  = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } status_t;

endpackage

// ----- rtl/bounded_stack_with_search.sv -----
// bounded lifo stack of signed words with search and dump, top level
//
// An item is taken when start is high and busy is low; every result appears for one cycle
// with strobe high and cannot be stalled. Push, clear, unused codes and pop from zero or
// one entry return their single result in the cycle after the item and free the block at
// once, so they run at one item per cycle. Pop from two or more entries goes through the
// pop state, since the new top word is read back from the entry memory. Search and dump
// walk min(count, 16) entries: one read port reads them from the top, one per cycle, and
// each match is held back until the next one so that the final result carries last. An
// empty stack gives one result with status empty in the next cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bounded_stack_with_search #(
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [bsws_pkg::OP_W-1:0]           operation,
    input  logic signed [bsws_pkg::WORD_W-1:0]  value,
    input  logic                                capacity_write,
    input  logic [bsws_pkg::CAP_W-1:0]          capacity,
    output logic                                strobe,
    output logic [bsws_pkg::STATUS_W-1:0]       status,
    output logic                                item_valid,
    output logic [bsws_pkg::POS_W-1:0]          item_position,
    output logic signed [bsws_pkg::WORD_W-1:0]  item_value,
    output logic                                last,
    output logic [bsws_pkg::COUNT_W-1:0]        count,
    output logic                                full_res,
    output logic signed [bsws_pkg::WORD_W-1:0]  top_value
);

    import bsws_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_WALK,
        S_FLUSH
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [WORD_W-1:0]   top_reg, top_next;
    logic [CAP_W-1:0]    cap_reg, cap_next;
    logic [WORD_W-1:0]   key_reg, key_next;
    logic                dump_reg, dump_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [POS_W-1:0]    iss_pos_reg, iss_pos_next;
    logic                iss_done_reg, iss_done_next;
    logic [POS_W-1:0]    walk_m1_reg, walk_m1_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [POS_W-1:0]    rd_pos_reg, rd_pos_next;
    logic                pend_vld_reg, pend_vld_next;
    logic [POS_W-1:0]    pend_pos_reg, pend_pos_next;
    logic [WORD_W-1:0]   pend_val_reg, pend_val_next;
    logic                strobe_reg, strobe_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                item_valid_reg, item_valid_next;
    logic [POS_W-1:0]    item_pos_reg, item_pos_next;
    logic [WORD_W-1:0]   item_val_reg, item_val_next;
    logic                last_reg, last_next;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [WORD_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [WORD_W-1:0]   mem_rdata;

    logic [EW-1:0]       cnt_ext;
    logic [EW-1:0]       cnt_m1;
    logic [EW-1:0]       cnt_m2;
    logic [EW-1:0]       cap_ext;
    logic [EW-1:0]       eff_cap;
    logic                full_now;
    logic                accept;
    logic                match;

    bsws_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cnt_ext  = EW'(count_reg);
    assign cnt_m1   = cnt_ext - EW'(1);
    assign cnt_m2   = cnt_ext - EW'(2);
    assign cap_ext  = EW'(cap_reg);
    assign eff_cap  = (cap_ext > EW'(DEPTH)) ? EW'(DEPTH) : cap_ext;
    assign full_now = (cnt_ext >= eff_cap);
    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign match    = dump_reg || (mem_rdata == key_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        top_next        = top_reg;
        cap_next        = capacity_write ? capacity : cap_reg;
        key_next        = key_reg;
        dump_next       = dump_reg;
        addr_next       = addr_reg;
        iss_pos_next    = iss_pos_reg;
        iss_done_next   = iss_done_reg;
        walk_m1_next    = walk_m1_reg;
        rd_vld_next     = 1'b0;
        rd_pos_next     = rd_pos_reg;
        pend_vld_next   = pend_vld_reg;
        pend_pos_next   = pend_pos_reg;
        pend_val_next   = pend_val_reg;
        strobe_next     = 1'b0;
        status_next     = status_reg;
        item_valid_next = item_valid_reg;
        item_pos_next   = item_pos_reg;
        item_val_next   = item_val_reg;
        last_next       = last_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[AW-1:0];
        mem_wdata       = value;
        mem_re          = 1'b0;
        mem_raddr       = addr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // single result by default
                    strobe_next     = 1'b1;
                    last_next       = 1'b1;
                    status_next     = STS_DONE;
                    item_valid_next = 1'b0;
                    item_pos_next   = '0;
                    item_val_next   = '0;
                    case (op_t'(operation))
                        OP_PUSH:
                        begin
                            if (full_now)
                            begin
                                status_next = STS_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                                top_next   = value;
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STS_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                if (count_reg == CW'(1))
                                begin
                                    top_next = '0;
                                end
                                else
                                begin
                                    // new top comes back from memory next cycle
                                    strobe_next = 1'b0;
                                    mem_re      = 1'b1;
                                    mem_raddr   = cnt_m2[AW-1:0];
                                    state_next  = S_POP;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STS_EMPTY;
                            end
                            else
                            begin
                                count_next = '0;
                                top_next   = '0;
                            end
                        end
                        OP_SEARCH, OP_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STS_EMPTY;
                            end
                            else
                            begin
                                strobe_next   = 1'b0;
                                key_next      = value;
                                dump_next     = (op_t'(operation) == OP_DUMP);
                                addr_next     = cnt_m1[AW-1:0];
                                iss_pos_next  = '0;
                                iss_done_next = 1'b0;
                                walk_m1_next  = (cnt_ext > EW'(WALK_MAX)) ?
                                                POS_W'(WALK_MAX - 1) : cnt_m1[POS_W-1:0];
                                pend_vld_next = 1'b0;
                                state_next    = S_WALK;
                            end
                        end
                        default:
                        begin
                            status_next = STS_DONE;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                top_next        = mem_rdata;
                strobe_next     = 1'b1;
                last_next       = 1'b1;
                status_next     = STS_DONE;
                item_valid_next = 1'b0;
                item_pos_next   = '0;
                item_val_next   = '0;
                state_next      = S_IDLE;
            end
            S_WALK:
            begin
                // issue one read per cycle from the top down
                if (!iss_done_reg)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = addr_reg;
                    addr_next     = addr_reg - AW'(1);
                    rd_vld_next   = 1'b1;
                    rd_pos_next   = iss_pos_reg;
                    iss_pos_next  = iss_pos_reg + POS_W'(1);
                    iss_done_next = (iss_pos_reg == walk_m1_reg);
                end
                // hold each match back until the next one shows whether it is final
                if (rd_vld_reg)
                begin
                    if (match)
                    begin
                        if (pend_vld_reg)
                        begin
                            strobe_next     = 1'b1;
                            last_next       = 1'b0;
                            status_next     = STS_DONE;
                            item_valid_next = 1'b1;
                            item_pos_next   = pend_pos_reg;
                            item_val_next   = pend_val_reg;
                        end
                        pend_vld_next = 1'b1;
                        pend_pos_next = rd_pos_reg;
                        pend_val_next = mem_rdata;
                    end
                    if (rd_pos_reg == walk_m1_reg)
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH:
            begin
                strobe_next     = 1'b1;
                last_next       = 1'b1;
                status_next     = STS_DONE;
                item_valid_next = pend_vld_reg;
                item_pos_next   = pend_vld_reg ? pend_pos_reg : '0;
                item_val_next   = pend_vld_reg ? pend_val_reg : '0;
                pend_vld_next   = 1'b0;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            top_reg        <= '0;
            cap_reg        <= CAP_W'(16);
            key_reg        <= '0;
            dump_reg       <= 1'b0;
            addr_reg       <= '0;
            iss_pos_reg    <= '0;
            iss_done_reg   <= 1'b1;
            walk_m1_reg    <= '0;
            rd_vld_reg     <= 1'b0;
            rd_pos_reg     <= '0;
            pend_vld_reg   <= 1'b0;
            pend_pos_reg   <= '0;
            pend_val_reg   <= '0;
            strobe_reg     <= 1'b0;
            status_reg     <= STS_DONE;
            item_valid_reg <= 1'b0;
            item_pos_reg   <= '0;
            item_val_reg   <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            top_reg        <= top_next;
            cap_reg        <= cap_next;
            key_reg        <= key_next;
            dump_reg       <= dump_next;
            addr_reg       <= addr_next;
            iss_pos_reg    <= iss_pos_next;
            iss_done_reg   <= iss_done_next;
            walk_m1_reg    <= walk_m1_next;
            rd_vld_reg     <= rd_vld_next;
            rd_pos_reg     <= rd_pos_next;
            pend_vld_reg   <= pend_vld_next;
            pend_pos_reg   <= pend_pos_next;
            pend_val_reg   <= pend_val_next;
            strobe_reg     <= strobe_next;
            status_reg     <= status_next;
            item_valid_reg <= item_valid_next;
            item_pos_reg   <= item_pos_next;
            item_val_reg   <= item_val_next;
            last_reg       <= last_next;
        end
    end

    assign strobe        = strobe_reg;
    assign status        = status_reg;
    assign item_valid    = item_valid_reg;
    assign item_position = item_pos_reg;
    assign item_value    = item_val_reg;
    assign last          = last_reg;
    assign count         = cnt_ext[COUNT_W-1:0];
    assign full_res      = full_now;
    assign top_value     = top_reg;

    `ASSERT_CLK(a_count_bound, clk, rst_n, count_reg <= CW'(DEPTH), "count above depth")
    `ASSERT_CLK(a_push_result, clk, rst_n,
        accept && operation == OP_PUSH |=> strobe_reg && last_reg,
        "push gave no final result")
    `ASSERT_CLK(a_pop_result, clk, rst_n,
        state_reg == S_POP |=> strobe_reg && last_reg && state_reg == S_IDLE,
        "pop readback gave no final result")
    `ASSERT_CLK(a_flush_result, clk, rst_n,
        state_reg == S_FLUSH |=> strobe_reg && last_reg,
        "walk ended without final result")
    `ASSERT_NEVER(a_pend_idle, clk, rst_n,
        pend_vld_reg && state_reg == S_IDLE,
        "held match left behind in idle")
    `ASSERT_NEVER(a_item_status, clk, rst_n,
        strobe_reg && item_valid_reg && status_reg != STS_DONE,
        "item with error status")

endmodule

// ----- rtl/bsws_ram.sv -----
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module bsws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
